// ----- design/retransmit_timer_queue_assert.svh -----
// Assertion helpers for the retransmit timer queue.
`ifndef RETRANSMIT_TIMER_QUEUE_ASSERT_SVH
`define RETRANSMIT_TIMER_QUEUE_ASSERT_SVH

// Clocked check, idle while reset is asserted.
`define RTQ_ASSERT(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Implication checked in the cycle after the condition.
`define RTQ_ASSERT_NEXT(name, cond, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (prop)) \
		else $error(msg);

`endif

// ----- design/rtq_pkg.sv -----
package rtq_pkg;

	localparam int DEF_DEPTH = 16;
	localparam int SEQ_W     = 16;
	localparam int TIME_W    = 32;
	localparam int TMO_W     = 16;
	localparam int ACT_W     = 3;
	localparam int STAT_W    = 2;
	localparam int OCC_W     = 5;
	localparam int IN_W      = 56;
	localparam int OUT_W     = 56;
	localparam logic [TMO_W-1:0] TMO_RESET = 16'd3;

	localparam logic [ACT_W-1:0] ACT_ADD    = 3'd0;
	localparam logic [ACT_W-1:0] ACT_REMOVE = 3'd1;
	localparam logic [ACT_W-1:0] ACT_RESEND = 3'd2;
	localparam logic [ACT_W-1:0] ACT_TICK   = 3'd3;
	localparam logic [ACT_W-1:0] ACT_CLEAR  = 3'd4;

	localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
	localparam logic [STAT_W-1:0] ST_FULL     = 2'd1;
	localparam logic [STAT_W-1:0] ST_NOTFOUND = 2'd2;

	typedef struct packed {
		logic [TIME_W-1:0] deadline;
		logic [SEQ_W-1:0]  seq;
	} entry_t;

endpackage

// ----- design/rtq_mem.sv -----
module rtq_mem
	import rtq_pkg::*;
#(
	parameter int DEPTH = DEF_DEPTH,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  entry_t        wr_data,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output entry_t        rd_data
);

	entry_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		// read data holds until the next read
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ----- design/retransmit_timer_queue.sv -----
// Retransmit timer queue.
// Input stream s_axis_*: one word per command (add, remove, resend, tick, clear).
// Output stream m_axis_*: one or more result words per command, tlast on the final one.
// Write cfg_wr_en/cfg_wr_data to set the resend timeout (reset value 3).
// Entries live in one circular RAM (one write, one registered read port).
// Add and clear: go straight to the final state, which loads the result word.
// Remove / resend: entries are searched one by one from the head, then each later
// entry is moved up one place to close the gap.
// Tick: each expired entry at the head is re-queued at the tail with a new deadline.
// One command is in flight at a time; s_axis_tready is high while the
// sequencer is idle, even while the last result word still waits in the
// output register.
// When m_axis_tready is low the sequencer holds before its next result word;
// nothing is dropped.
// Reset empties the queue and clears the resend counter and the output valid flag.
module retransmit_timer_queue
	import rtq_pkg::*;
#(
	parameter int QUEUE_DEPTH = DEF_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_wr_en,
	input  logic [TMO_W-1:0] cfg_wr_data,   // retransmit timeout
	input  logic             s_axis_tvalid,
	output logic             s_axis_tready,
	input  logic [IN_W-1:0]  s_axis_tdata,  // action[2:0], seq[18:3], now_time[50:19]
	output logic             m_axis_tvalid,
	input  logic             m_axis_tready,
	// resend_valid[0], resend_seq[16:1], status[18:17], occupancy[23:19],
	// resend_total[55:24]
	output logic [OUT_W-1:0] m_axis_tdata,
	output logic             m_axis_tlast
);

	`include "retransmit_timer_queue_assert.svh"

	localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [2:0] {
		IDLE, S_CMP, SH, SH_END, T_CHK, T_FIN, FIN
	} state_t;

	state_t            state_q;
	logic [CW-1:0]     count_q, idx_q, budget_q, k_q;
	logic [AW-1:0]     head_q;
	logic [TMO_W-1:0]  timeout_q;
	logic [TIME_W-1:0] total_q;
	logic [ACT_W-1:0]  act_q;
	logic [SEQ_W-1:0]  seq_q, pend_seq_q;
	logic [TIME_W-1:0] now_q, dl_q;
	logic              rv_q, pend_q;
	logic [STAT_W-1:0] stat_q;

	logic              out_valid_q, out_last_q, out_rv_q;
	logic [SEQ_W-1:0]  out_seq_q;
	logic [STAT_W-1:0] out_stat_q;
	logic [OCC_W-1:0]  out_occ_q;
	logic [TIME_W-1:0] out_total_q;

	logic [ACT_W-1:0]  in_act;
	logic [SEQ_W-1:0]  in_seq;
	logic [TIME_W-1:0] in_now, in_dl;
	logic [TIME_W:0]   dl_sum;
	logic              in_acc, out_free, out_load, expired, t_go, match;
	logic [AW-1:0]     head_inc;

	logic              wr_en, rd_en;
	logic [AW-1:0]     wr_addr, rd_addr;
	entry_t            wr_data, rd_data;

	function automatic logic [AW-1:0] phys(input logic [AW-1:0] h, input logic [CW-1:0] l);
		logic [CW:0] s;
		s = (CW+1)'(h) + (CW+1)'(l);
		if (s >= (CW+1)'(QUEUE_DEPTH)) begin
			s = s - (CW+1)'(QUEUE_DEPTH);
		end
		return s[AW-1:0];
	endfunction

	assign in_act = s_axis_tdata[2:0];
	assign in_seq = s_axis_tdata[18:3];
	assign in_now = s_axis_tdata[50:19];
	assign dl_sum = (TIME_W+1)'(in_now) + (TIME_W+1)'(timeout_q);
	assign in_dl  = dl_sum[TIME_W] ? '1 : dl_sum[TIME_W-1:0];

	assign s_axis_tready = (state_q == IDLE);
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign out_free      = !out_valid_q || m_axis_tready;
	assign expired       = (now_q >= rd_data.deadline);
	assign t_go          = expired && (!pend_q || out_free);
	assign match         = (rd_data.seq == seq_q);
	assign head_inc      = phys(head_q, CW'(1));
	// output register is loaded this cycle
	assign out_load      = (state_q == T_CHK && t_go && pend_q)
			|| ((state_q == T_FIN || state_q == FIN) && out_free);

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = phys(head_q, count_q);
		wr_data = '{deadline: dl_q, seq: seq_q};
		rd_en   = 1'b0;
		rd_addr = head_q;
		unique case (state_q)
			IDLE: begin
				if (in_acc) begin
					if (in_act == ACT_ADD && count_q < CW'(QUEUE_DEPTH)) begin
						wr_en   = 1'b1;
						wr_data = '{deadline: in_dl, seq: in_seq};
					end
					if ((in_act == ACT_REMOVE || in_act == ACT_RESEND || in_act == ACT_TICK)
							&& count_q != '0) begin
						rd_en = 1'b1;
					end
				end
			end
			S_CMP: begin
				if ((CW+1)'(idx_q) + 1 < (CW+1)'(count_q)) begin
					rd_en   = 1'b1;
					rd_addr = phys(head_q, idx_q + CW'(1));
				end
			end
			SH: begin
				wr_en   = 1'b1;
				wr_addr = phys(head_q, idx_q);
				wr_data = rd_data;
				if ((CW+1)'(idx_q) + 2 < (CW+1)'(count_q)) begin
					rd_en   = 1'b1;
					rd_addr = phys(head_q, idx_q + CW'(2));
				end
			end
			SH_END: begin
				if (act_q == ACT_RESEND) begin
					wr_en   = 1'b1;
					wr_addr = phys(head_q, idx_q);
				end
			end
			T_CHK: begin
				if (t_go) begin
					wr_en   = 1'b1;
					wr_data = '{deadline: dl_q, seq: rd_data.seq};
					if ((CW+1)'(k_q) + 1 < (CW+1)'(budget_q)) begin
						rd_en   = 1'b1;
						rd_addr = head_inc;
					end
				end
			end
			default: ;
		endcase
	end

	rtq_mem #(
		.DEPTH (QUEUE_DEPTH),
		.AW    (AW)
	) u_mem (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= TMO_RESET;
		end else if (cfg_wr_en) begin
			timeout_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= IDLE;
			count_q     <= '0;
			head_q      <= '0;
			total_q     <= '0;
			pend_q      <= 1'b0;
			out_valid_q <= 1'b0;
			idx_q       <= '0;
			k_q         <= '0;
			budget_q    <= '0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				IDLE: begin
					if (in_acc) begin
						act_q    <= in_act;
						seq_q    <= in_seq;
						now_q    <= in_now;
						dl_q     <= in_dl;
						idx_q    <= '0;
						k_q      <= '0;
						budget_q <= count_q;
						pend_q   <= 1'b0;
						rv_q     <= 1'b0;
						stat_q   <= ST_OK;
						state_q  <= FIN;
						case (in_act) inside
							ACT_ADD: begin
								if (count_q < CW'(QUEUE_DEPTH)) begin
									count_q <= count_q + CW'(1);
								end else begin
									stat_q <= ST_FULL;
								end
							end
							ACT_REMOVE, ACT_RESEND: begin
								if (count_q != '0) begin
									state_q <= S_CMP;
								end else begin
									stat_q <= ST_NOTFOUND;
								end
							end
							ACT_TICK: begin
								if (count_q != '0) begin
									state_q <= T_CHK;
								end
							end
							ACT_CLEAR: begin
								count_q <= '0;
								head_q  <= '0;
							end
							default: ;
						endcase
					end
				end
				S_CMP: begin
					if (match) begin
						state_q <= ((CW+1)'(idx_q) + 1 < (CW+1)'(count_q)) ? SH : SH_END;
					end else if ((CW+1)'(idx_q) + 1 < (CW+1)'(count_q)) begin
						idx_q <= idx_q + CW'(1);
					end else begin
						stat_q  <= ST_NOTFOUND;
						state_q <= FIN;
					end
				end
				SH: begin
					idx_q <= idx_q + CW'(1);
					if ((CW+1)'(idx_q) + 2 >= (CW+1)'(count_q)) begin
						state_q <= SH_END;
					end
				end
				SH_END: begin
					if (act_q == ACT_RESEND) begin
						rv_q <= 1'b1;
					end else begin
						count_q <= count_q - CW'(1);
					end
					state_q <= FIN;
				end
				T_CHK: begin
					if (!expired) begin
						state_q <= T_FIN;
					end else if (t_go) begin
						// previous word is not the final one: release it now
						if (pend_q) begin
							out_rv_q    <= 1'b1;
							out_seq_q   <= pend_seq_q;
							out_stat_q  <= ST_OK;
							out_occ_q   <= OCC_W'(count_q);
							out_total_q <= total_q;
							out_last_q  <= 1'b0;
						end
						pend_q     <= 1'b1;
						pend_seq_q <= rd_data.seq;
						total_q    <= total_q + 1'b1;
						head_q     <= head_inc;
						k_q        <= k_q + CW'(1);
						if ((CW+1)'(k_q) + 1 >= (CW+1)'(budget_q)) begin
							state_q <= T_FIN;
						end
					end
				end
				T_FIN: begin
					if (out_free) begin
						out_rv_q    <= pend_q;
						out_seq_q   <= pend_q ? pend_seq_q : '0;
						out_stat_q  <= ST_OK;
						out_occ_q   <= OCC_W'(count_q);
						out_total_q <= total_q;
						out_last_q  <= 1'b1;
						pend_q      <= 1'b0;
						state_q     <= IDLE;
					end
				end
				FIN: begin
					if (out_free) begin
						out_rv_q    <= rv_q;
						out_seq_q   <= rv_q ? seq_q : '0;
						out_stat_q  <= stat_q;
						out_occ_q   <= OCC_W'(count_q);
						out_total_q <= total_q;
						out_last_q  <= 1'b1;
						state_q     <= IDLE;
					end
				end
				default: state_q <= IDLE;
			endcase
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tlast  = out_last_q;
	assign m_axis_tdata  = {out_total_q, out_occ_q, out_stat_q, out_seq_q, out_rv_q};

	`RTQ_ASSERT(a_count_range, count_q <= CW'(QUEUE_DEPTH), "occupancy beyond queue depth")
	`RTQ_ASSERT(a_head_range, (CW+1)'(head_q) < (CW+1)'(QUEUE_DEPTH), "head pointer out of range")
	`RTQ_ASSERT_NEXT(a_clear_empties, in_acc && in_act == ACT_CLEAR, count_q == '0, "clear left entries")
	`RTQ_ASSERT(a_pend_tick_only, pend_q |-> (state_q == T_CHK || state_q == T_FIN), "stray pending word")

endmodule
